// ----- design/fmdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fmdc_pkg
// shared widths, types and constants of the delay-conjugate fm discriminator
// ----------------------------------------------------------------------------
package fmdc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int ANGLE_STAGES = 16;

  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DEMOD_W = 24;

  // conjugate product terms and cordic datapath
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int CORDIC_W = PROD_W + 3;
  localparam int SHIFT_W = (ANGLE_STAGES > 1) ? $clog2(ANGLE_STAGES) : 1;

  // scaling datapath
  localparam int DIFF_W  = ANGLE_W + 1;
  localparam int MUL_W   = 2 * DIFF_W;
  localparam int ROUND_W = MUL_W + 1;

  localparam logic [ANGLE_W-1:0] ANGLE_PI = {1'b1, {(ANGLE_W-1){1'b0}}};

  // configuration register indexes
  localparam logic CFG_CARRIER_STEP = 1'b0;
  localparam logic CFG_DEVIATION_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ANGLE_W-1:0]     angle_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic signed [DEMOD_W-1:0]     demod_t;

  typedef struct packed {
    logic                       valid;
    logic                       zero;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ANGLE_W-1:0]         z;
  } cordic_word_t;

  // rounded arctangent of 2^-i, pi = 32768
  function automatic logic [ANGLE_W-1:0] atan_of(input logic [SHIFT_W-1:0] shift);
    logic [ANGLE_W-1:0] a;
    case (int'(shift))
      0:  a = 16'd8192;
      1:  a = 16'd4836;
      2:  a = 16'd2555;
      3:  a = 16'd1297;
      4:  a = 16'd651;
      5:  a = 16'd326;
      6:  a = 16'd163;
      7:  a = 16'd81;
      8:  a = 16'd41;
      9:  a = 16'd20;
      10: a = 16'd10;
      11: a = 16'd5;
      12: a = 16'd3;
      13: a = 16'd1;
      14: a = 16'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/fmdc_if.sv -----
// ----------------------------------------------------------------------------
// fmdc channel interfaces
// valid/ready channels for input samples and demodulated words
// ----------------------------------------------------------------------------
interface fmdc_sample_if import fmdc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_i;
  sample_t sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fmdc_demod_if import fmdc_pkg::*; ();
  logic   valid;
  logic   ready;
  demod_t demod_value;
  logic   saturated;

  modport source (output valid, output demod_value, output saturated, input ready);
  modport sink   (input valid, input demod_value, input saturated, output ready);
endinterface

// ----- design/fmdc_conj_mult.sv -----
// ----------------------------------------------------------------------------
// fmdc_conj_mult
// product with the conjugate of the previous sample, then half-plane fold
// ----------------------------------------------------------------------------
module fmdc_conj_mult import fmdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         accept,
  input  sample_t      sample_i,
  input  sample_t      sample_q,
  output cordic_word_t dout
);

  sample_t previous_i;
  sample_t previous_q;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] p_ii;
  logic signed [PROD_W-1:0] p_qq;
  logic signed [PROD_W-1:0] p_iq;
  logic signed [PROD_W-1:0] p_qi;

  logic signed [CORDIC_W-1:0] re;
  logic signed [CORDIC_W-1:0] im;
  cordic_word_t               dout_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_i <= '0;
      previous_q <= '0;
    end else if (accept) begin
      previous_i <= sample_i;
      previous_q <= sample_q;
    end
  end

  // stage a: four partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_ii <= previous_i * sample_i;
      p_qq <= previous_q * sample_q;
      p_iq <= previous_i * sample_q;
      p_qi <= previous_q * sample_i;
    end
  end

  // stage b: sum and fold into the right half plane
  always_comb begin
    re = CORDIC_W'(p_ii) + CORDIC_W'(p_qq);
    im = CORDIC_W'(p_iq) - CORDIC_W'(p_qi);
    dout_next.valid = prod_valid;
    dout_next.zero  = (re == '0) && (im == '0);
    if (re[CORDIC_W-1]) begin
      dout_next.x = -re;
      dout_next.y = -im;
      dout_next.z = ANGLE_PI;
    end else begin
      dout_next.x = re;
      dout_next.y = im;
      dout_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= dout_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dout.zero <= dout_next.zero;
      dout.x    <= dout_next.x;
      dout.y    <= dout_next.y;
      dout.z    <= dout_next.z;
    end
  end

endmodule

// ----- design/fmdc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// fmdc_cordic_cell
// one vectoring micro-rotation, registered toward the next cell
// ----------------------------------------------------------------------------
module fmdc_cordic_cell import fmdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [SHIFT_W-1:0] shift,
  input  cordic_word_t       din,
  output cordic_word_t       dout
);

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic [ANGLE_W-1:0]         a;
  cordic_word_t               dout_next;

  always_comb begin
    xs = din.x >>> shift;
    ys = din.y >>> shift;
    a  = atan_of(shift);
    dout_next.valid = din.valid;
    dout_next.zero  = din.zero;
    // y of zero turns clockwise like a positive y
    if (!din.y[CORDIC_W-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + a;
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= dout_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dout.zero <= dout_next.zero;
      dout.x    <= dout_next.x;
      dout.y    <= dout_next.y;
      dout.z    <= dout_next.z;
    end
  end

endmodule

// ----- design/fmdc_scaler.sv -----
// ----------------------------------------------------------------------------
// fmdc_scaler
// carrier removal, gain multiply, rounding and saturation to the output word
// ----------------------------------------------------------------------------
module fmdc_scaler import fmdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  cordic_word_t din,
  input  angle_t       carrier_phase_step,
  input  gain_t        deviation_gain,
  output logic         out_valid,
  output demod_t       demod_value,
  output logic         saturated
);

  angle_t                    angle;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  gain_s;
  logic                      mul_valid;
  logic signed [MUL_W-1:0]   prod;
  logic signed [ROUND_W-1:0] rounded;
  logic                      over;
  demod_t                    value_next;

  always_comb begin
    angle  = din.zero ? angle_t'(0) : angle_t'(din.z);
    diff   = DIFF_W'(angle) - DIFF_W'(carrier_phase_step);
    gain_s = $signed({1'b0, deviation_gain});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= diff * gain_s;
    end
  end

  // divide by 256 rounding half up, then clip to the output range
  always_comb begin
    rounded = ROUND_W'(prod) + ROUND_W'(128);
    over = (rounded[ROUND_W-1:DEMOD_W+7] != '0) &&
           (rounded[ROUND_W-1:DEMOD_W+7] != '1);
    if (!over) begin
      value_next = rounded[DEMOD_W+7:8];
    end else if (rounded[ROUND_W-1]) begin
      value_next = {1'b1, {(DEMOD_W-1){1'b0}}};
    end else begin
      value_next = {1'b0, {(DEMOD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      demod_value <= value_next;
      saturated   <= over;
    end
  end

endmodule

// ----- design/fm_delay_conjugate_discriminator.sv -----
// ----------------------------------------------------------------------------
// fm_delay_conjugate_discriminator
// fm quadrature discriminator: delay-conjugate product and cordic angle
// ----------------------------------------------------------------------------
// usage
//   samples: one complex i/q word per handshake (valid/ready)
//   demod:   one demodulated word per input word, same order, with a flag
//            that marks a clipped value
//   cfg:     cfg_write/cfg_index/cfg_data, index 0 carrier_phase_step,
//            index 1 deviation_gain; write only while the pipe is empty
// latency: ANGLE_STAGES + 4 cycles from acceptance to demod.valid (20 here)
//   product, fold, one cycle per cordic cell, gain multiply, output register
// throughput: one word per cycle; every stage moves together, so the rate
//   is that of the cell chain with all cells busy
// reset: pipe empties, previous sample clears to zero (the first word after
//   reset sees a zero vector and gives angle 0), step 0, gain 1.0
// stall: while demod holds a word that is not taken, the whole chain holds
//   and samples.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module fm_delay_conjugate_discriminator import fmdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fmdc_sample_if.sink       samples,
  fmdc_demod_if.source      demod,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  // configuration registers
  angle_t carrier_phase_step;
  gain_t  deviation_gain;

  // pipeline control
  logic advance;
  logic accept;

  // cordic chain: element 0 comes from the product stage
  cordic_word_t chain [ANGLE_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase_step <= '0;
      deviation_gain     <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CARRIER_STEP:   carrier_phase_step <= angle_t'(cfg_data);
        CFG_DEVIATION_GAIN: deviation_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // the chain moves when the output register is empty or being taken
  assign advance       = !demod.valid || demod.ready;
  assign samples.ready = advance;
  assign accept        = samples.valid && advance;

  fmdc_conj_mult u_conj_mult (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .accept   (accept),
    .sample_i (samples.sample_i),
    .sample_q (samples.sample_q),
    .dout     (chain[0])
  );

  // one micro-rotation per cell, shift equal to the cell position
  for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
    fmdc_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .shift   (SHIFT_W'(g)),
      .din     (chain[g]),
      .dout    (chain[g+1])
    );
  end

  fmdc_scaler u_scaler (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .din                (chain[ANGLE_STAGES]),
    .carrier_phase_step (carrier_phase_step),
    .deviation_gain     (deviation_gain),
    .out_valid          (demod.valid),
    .demod_value        (demod.demod_value),
    .saturated          (demod.saturated)
  );

  // a clipped word sits at one end of the range
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    demod.valid && demod.saturated |->
      (demod.demod_value == {1'b0, {(DEMOD_W-1){1'b1}}}) ||
      (demod.demod_value == {1'b1, {(DEMOD_W-1){1'b0}}}))
    else $error("saturated word not at a range limit");

  // reset leaves no word at the output
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !demod.valid)
    else $error("output word present right after reset");

  // a held output word blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    demod.valid && !demod.ready |-> !samples.ready)
    else $error("input taken while output stalled");

  // a word that is not taken stays put until it is
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    demod.valid && !demod.ready |=>
      demod.valid && $stable(demod.demod_value) && $stable(demod.saturated))
    else $error("output word changed while stalled");

endmodule

// ----- test/fmdc_demod_monitor.sv -----
// ----------------------------------------------------------------------------
// fmdc_demod_monitor
// watches the sample, demod and config ports of the discriminator, predicts
// each demod word from the accepted samples and compares field by field
// ----------------------------------------------------------------------------
module fmdc_demod_monitor import fmdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fmdc_sample_if            samples,
  fmdc_demod_if             demod,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    demod_t value;
    logic   clipped;
  } demod_word_t;

  // rounded arctangent of 2^-k, pi = 32768
  localparam longint ARCTAN [0:23] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  localparam longint DEMOD_MAX = 64'sd8388607;
  localparam longint DEMOD_MIN = -64'sd8388608;

  sample_t     last_i;
  sample_t     last_q;
  angle_t      carrier_step;
  gain_t       deviation_gain;
  demod_word_t demod_q[$];
  int          mismatch_count = 0;

  function automatic angle_t cordic_angle(input longint re, input longint im);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint a;
    x = re;
    y = im;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane: turn by pi first
    if (x < 0) begin
      z = (y >= 0) ? 64'sd32768 : -64'sd32768;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < ANGLE_STAGES; k++) begin
      a  = (k < 24) ? ARCTAN[k] : 0;
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + a;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - a;
      end
    end
    return angle_t'(z);
  endfunction

  function automatic demod_word_t predict_demod(input sample_t yi, input sample_t yq);
    longint      re;
    longint      im;
    longint      scaled;
    angle_t      ang;
    demod_word_t w;
    re  = longint'(last_i) * longint'(yi) + longint'(last_q) * longint'(yq);
    im  = longint'(last_i) * longint'(yq) - longint'(last_q) * longint'(yi);
    ang = cordic_angle(re, im);
    // divide by 256, half rounds up
    scaled = ((longint'(ang) - longint'(carrier_step)) * longint'(deviation_gain) + 128) >>> 8;
    w.clipped = 1'b1;
    if (scaled > DEMOD_MAX) scaled = DEMOD_MAX;
    else if (scaled < DEMOD_MIN) scaled = DEMOD_MIN;
    else w.clipped = 1'b0;
    w.value = demod_t'(scaled);
    return w;
  endfunction

  always @(posedge clk) begin : track
    demod_word_t want;
    if (rst) begin
      last_i         = '0;
      last_q         = '0;
      carrier_step   = '0;
      deviation_gain = GAIN_RESET;
      demod_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_CARRIER_STEP) carrier_step = angle_t'(cfg_data);
        else deviation_gain = cfg_data;
      end
      if (demod.valid && demod.ready) begin
        if (demod_q.size() == 0) begin
          $error("demod word with nothing expected: demod_value %0d saturated %0b",
                 demod.demod_value, demod.saturated);
          mismatch_count++;
        end else begin
          want = demod_q.pop_front();
          if (demod.demod_value !== want.value) begin
            $error("demod_value mismatch: expected %0d, actual %0d",
                   want.value, demod.demod_value);
            mismatch_count++;
          end
          if (demod.saturated !== want.clipped) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   want.clipped, demod.saturated);
            mismatch_count++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        demod_q.push_back(predict_demod(samples.sample_i, samples.sample_q));
        last_i = samples.sample_i;
        last_q = samples.sample_q;
      end
    end
    errors  <= mismatch_count;
    pending <= demod_q.size();
  end

endmodule

// ----- test/fm_delay_conjugate_discriminator_tb.sv -----
// ----------------------------------------------------------------------------
// fm_delay_conjugate_discriminator_tb
// drives i/q words through the discriminator under random valid and ready
// gaps, reprograms step and gain between phases, and reports the verdict of
// the monitor that predicts and checks every demod word
// ----------------------------------------------------------------------------
module fm_delay_conjugate_discriminator_tb import fmdc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam real PI = 3.14159265358979;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_index;
  logic [GAIN_W-1:0] cfg_data;
  int                fail_count;
  int                in_flight;

  // handshake between stimulus and the demod drain
  bit hold_request = 1'b0;   // ask the drain for one long hold-off
  bit steady       = 1'b0;   // no idle cycles on either side

  fmdc_sample_if samples();
  fmdc_demod_if  demod();

  fm_delay_conjugate_discriminator u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .demod     (demod),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fmdc_demod_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .demod     (demod),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (fail_count),
    .pending   (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // idle length for the sample side: mostly none, some short, few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one sample word: optional idle gap, then hold valid until it is taken
  task automatic send_word(input sample_t yi, input sample_t yq);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid    <= 1'b1;
    samples.sample_i <= yi;
    samples.sample_q <= yq;
    do @(posedge clk); while (!samples.ready);
  endtask

  // drop valid, wait until every demod word is out, then write one register
  task automatic write_reg(input logic idx, input logic [GAIN_W-1:0] data);
    samples.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_config(input angle_t step, input gain_t gain);
    write_reg(CFG_CARRIER_STEP, step);
    write_reg(CFG_DEVIATION_GAIN, gain);
  endtask

  // one random component: near zero, an extreme, or anything
  function automatic sample_t pick_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return sample_t'(int'($urandom_range(0, 8)) - 4);
    if (r < 20) begin
      case ($urandom_range(0, 4))
        0: return sample_t'(-32768);
        1: return sample_t'(32767);
        2: return sample_t'(0);
        3: return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // random words: mostly runs of a rotating phasor (an fm tone with random
  // amplitude and frequency), the rest runs of unrelated noise words
  task automatic run_random(input int count);
    int  left;
    int  len;
    real ph;
    real dph;
    real amp;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 99) < 65) ? $urandom_range(8, 40) : $urandom_range(1, 20);
      if (len > left) len = left;
      if ($urandom_range(0, 99) < 65) begin
        ph  = PI * (real'(int'($urandom_range(0, 65535))) - 32768.0) / 32768.0;
        dph = PI * (real'(int'($urandom_range(0, 65535))) - 32768.0) / 32768.0;
        amp = real'(int'($urandom_range(1, 32767)));
        repeat (len) begin
          send_word(sample_t'($rtoi($floor(amp * $cos(ph) + 0.5))),
                    sample_t'($rtoi($floor(amp * $sin(ph) + 0.5))));
          ph = ph + dph;
        end
      end else begin
        repeat (len) send_word(pick_component(), pick_component());
      end
      left = left - len;
    end
  endtask

  // demod side: ready runs and stalls of random length, and one long
  // counted hold-off when stimulus asks for it
  initial begin : drain
    int r;
    int run;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        demod.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
          demod.ready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (r < 95) begin
          demod.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          demod.ready <= 1'b0;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_CARRIER_STEP;
    cfg_data         <= '0;
    samples.valid    <= 1'b0;
    samples.sample_i <= '0;
    samples.sample_q <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset config (step 0, gain 1.0)
    // first word after reset meets a zero previous sample: angle 0
    send_word(sample_t'(32767), sample_t'(0));
    send_word(sample_t'(32767), sample_t'(0));      // same point, angle 0
    send_word(sample_t'(0), sample_t'(32767));      // quarter turn
    send_word(sample_t'(16384), sample_t'(0));
    send_word(sample_t'(-16384), sample_t'(0));     // exactly half a turn
    send_word(sample_t'(-32768), sample_t'(-32768));
    send_word(sample_t'(32767), sample_t'(32767));
    send_word(sample_t'(-32768), sample_t'(32767));
    send_word(sample_t'(32767), sample_t'(-32768));
    send_word(sample_t'(0), sample_t'(0));          // zero input word
    send_word(sample_t'(1), sample_t'(0));          // zero product again
    send_word(sample_t'(0), sample_t'(1));
    send_word(sample_t'(-1), sample_t'(0));
    send_word(sample_t'(0), sample_t'(-1));
    send_word(sample_t'(1), sample_t'(-1));

    // largest gain with the step at its negative extreme: clip high
    program_config(angle_t'(-32768), gain_t'(65535));
    send_word(sample_t'(32767), sample_t'(0));
    send_word(sample_t'(-32768), sample_t'(1));

    // step at its positive extreme: clip low
    program_config(angle_t'(32767), gain_t'(65535));
    send_word(sample_t'(32767), sample_t'(0));
    send_word(sample_t'(-32768), sample_t'(-1));

    // zero gain flattens everything to 0
    program_config(angle_t'(12345), gain_t'(0));
    send_word(sample_t'(0), sample_t'(32767));
    send_word(sample_t'(-32768), sample_t'(0));

    // random phases, each with its own step and gain
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_config(angle_t'($urandom), GAIN_RESET);
        1: program_config(angle_t'(32767), gain_t'(65535));
        2: program_config(angle_t'(-32768), GAIN_RESET);
        3: program_config(angle_t'($urandom), gain_t'(0));
        4: program_config(angle_t'($urandom), gain_t'($urandom_range(1, 255)));
        default: program_config(angle_t'($urandom), gain_t'($urandom_range(256, 65535)));
      endcase
      if (p == 0) begin
        // back-to-back words into a long demod hold-off: the pipe fills and
        // samples.ready has to drop
        hold_request = 1'b1;
        steady       = 1'b1;
        run_random(60);
        steady = 1'b0;
        run_random(40);
      end else if (p == 2) begin
        // a stretch with no idling on either side
        steady = 1'b1;
        run_random(50);
        steady = 1'b0;
        run_random(50);
      end else begin
        run_random(100);
      end
    end

    // drain: everything out, then let the pipe settle
    samples.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
